// ===== rtl/replica_slot_selector_top_macros.svh =====
// ----------------------------------------------------------------------------
// replica slot selector assertion macros
// concurrent assertion wrappers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef REPLICA_SLOT_SELECTOR_TOP_MACROS_SVH
`define REPLICA_SLOT_SELECTOR_TOP_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define RSS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define RSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define RSS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define RSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/rss_pkg.sv =====
// ----------------------------------------------------------------------------
// rss_pkg
// shared types, constants and helpers of the replica slot selector
// ----------------------------------------------------------------------------
package rss_pkg;

  // fixed geometry
  localparam int MaxReplicas = 4;
  localparam int MaxRacks    = 4;
  localparam int Slots       = 4;
  localparam int SlotW       = 2;
  localparam int IdxW        = 8;
  localparam int CntW        = 3;

  typedef enum logic [1:0] {
    KIND_MASTER  = 2'd0,
    KIND_SEQ     = 2'd1,
    KIND_RACK    = 2'd2,
    KIND_SEQ_ALT = 2'd3
  } kind_e;

  typedef logic [SlotW-1:0] slot_t;

  // stage 1: scan order worked out
  typedef struct packed {
    kind_e                             kind;
    logic [CntW-1:0]                   cnt;
    logic [CntW-1:0]                   nracks;
    logic [IdxW-1:0]                   start;
    logic [Slots-1:0]                  usable;
    logic [Slots-1:0]                  prev;
    logic [MaxRacks-1:0][Slots-1:0]    rack;
    slot_t [Slots-1:0]                 seq_slot;
    slot_t [Slots-1:0]                 rack_slot;
  } s1_t;

  // stage 2: per position candidate flags
  typedef struct packed {
    kind_e                             kind;
    logic [CntW-1:0]                   cnt;
    logic [IdxW-1:0]                   start;
    logic                              use0;
    slot_t [Slots-1:0]                 seq_slot;
    slot_t [Slots-1:0]                 rack_slot;
    logic [Slots-1:0]                  seq_hit;
    logic [MaxRacks-1:0][Slots-1:0]    hit;
    logic [MaxRacks-1:0][Slots-1:0]    fb1;
    logic [Slots-1:0]                  fb2;
  } s2_t;

  // stage 3: result
  typedef struct packed {
    logic            found;
    slot_t           slot;
    logic [IdxW-1:0] next;
  } res_t;

  // 9-bit value mod 3 by folding base-4 digits
  function automatic logic [1:0] mod3(input logic [8:0] x);
    logic [3:0] s;
    logic [2:0] t;
    logic [2:0] u;
    s = 4'(x[1:0]) + 4'(x[3:2]) + 4'(x[5:4]) + 4'(x[7:6]) + 4'(x[8]);
    t = 3'(s[1:0]) + 3'(s[3:2]);
    u = 3'(t[1:0]) + 3'(t[2]);
    mod3 = (u == 3'd3) ? 2'd0 : u[1:0];
  endfunction

  // value mod replica count, count already clamped to 0..4
  function automatic slot_t mod_count(input logic [8:0] x, input logic [CntW-1:0] cnt);
    unique case (cnt)
      3'd2:    mod_count = slot_t'(x[0]);
      3'd3:    mod_count = mod3(x);
      3'd4:    mod_count = x[1:0];
      default: mod_count = '0;
    endcase
  endfunction

endpackage

// ===== rtl/rss_order.sv =====
// ----------------------------------------------------------------------------
// rss_order
// first stage: clamps counts and works out the slot scan order of both
// rotating modes
// ----------------------------------------------------------------------------
module rss_order (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [1:0]                 kind_i,
  input  logic [rss_pkg::CntW-1:0]   replica_count_i,
  input  logic [rss_pkg::IdxW-1:0]   start_index_i,
  input  logic [rss_pkg::Slots-1:0]  slot_present_i,
  input  logic [rss_pkg::Slots-1:0]  slot_active_i,
  input  logic [rss_pkg::Slots-1:0]  slot_is_previous_i,
  input  logic [15:0]                rack_match_i,
  input  logic [rss_pkg::CntW-1:0]   rack_count_i,
  output rss_pkg::s1_t               s1_o
);
  import rss_pkg::*;

  s1_t s1_d, s1_q;

  // clamp and scan order
  always_comb begin
    logic [IdxW-1:0] seq8;
    logic [8:0]      rack9;
    s1_d.kind   = kind_e'(kind_i);
    s1_d.cnt    = (replica_count_i > CntW'(MaxReplicas)) ? CntW'(MaxReplicas)
                                                         : replica_count_i;
    s1_d.nracks = (rack_count_i > CntW'(MaxRacks)) ? CntW'(MaxRacks) : rack_count_i;
    s1_d.start  = start_index_i;
    s1_d.usable = slot_present_i & slot_active_i;
    s1_d.prev   = slot_is_previous_i;
    s1_d.rack   = rack_match_i;
    for (int i = 0; i < Slots; i++) begin
      // sequence index wraps at 8 bits, rack scan index does not
      seq8  = start_index_i + IdxW'(i);
      rack9 = {1'b0, start_index_i} + 9'(i);
      s1_d.seq_slot[i]  = mod_count({1'b0, seq8}, s1_d.cnt);
      s1_d.rack_slot[i] = mod_count(rack9, s1_d.cnt);
    end
  end

  // stage register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q <= s1_d;
    end
  end

  assign s1_o = s1_q;

endmodule

// ===== rtl/rss_match.sv =====
// ----------------------------------------------------------------------------
// rss_match
// second stage: flags each scan position as sequence hit, rack hit or fallback candidate
// ----------------------------------------------------------------------------
module rss_match (
  input  logic         clk_i,
  input  logic         en_i,
  input  rss_pkg::s1_t s1_i,
  output rss_pkg::s2_t s2_o
);
  import rss_pkg::*;

  s2_t s2_d, s2_q;

  always_comb begin
    logic  in_use;
    logic  fresh;
    slot_t sl;
    s2_d.kind      = s1_i.kind;
    s2_d.cnt       = s1_i.cnt;
    s2_d.start     = s1_i.start;
    s2_d.use0      = s1_i.usable[0];
    s2_d.seq_slot  = s1_i.seq_slot;
    s2_d.rack_slot = s1_i.rack_slot;
    // sequence positions
    for (int i = 0; i < Slots; i++) begin
      s2_d.seq_hit[i] = (CntW'(i) < s1_i.cnt) && s1_i.usable[s1_i.seq_slot[i]];
    end
    // prefer-rack positions
    for (int j = 0; j < Slots; j++) begin
      sl     = s1_i.rack_slot[j];
      in_use = (CntW'(j) < s1_i.cnt) && s1_i.usable[sl];
      fresh  = !s1_i.prev[sl];
      s2_d.fb2[j] = in_use && !fresh && (s1_i.nracks != '0);
      for (int r = 0; r < MaxRacks; r++) begin
        s2_d.hit[r][j] = in_use && fresh && (CntW'(r) < s1_i.nracks) && s1_i.rack[r][sl];
        s2_d.fb1[r][j] = in_use && fresh && (CntW'(r) < s1_i.nracks) && !s1_i.rack[r][sl];
      end
    end
  end

  // stage register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_q <= s2_d;
    end
  end

  assign s2_o = s2_q;

endmodule

// ===== rtl/rss_pick.sv =====
// ----------------------------------------------------------------------------
// rss_pick
// third stage: priority selection per mode and the output register
// ----------------------------------------------------------------------------
module rss_pick (
  input  logic          clk_i,
  input  logic          en_i,
  input  rss_pkg::s2_t  s2_i,
  output rss_pkg::res_t res_o
);
  import rss_pkg::*;

  res_t res_d, res_q;

  always_comb begin
    logic            sf, rf, f1, f2;
    slot_t           sslot, rslot, slot1, slot2;
    logic [IdxW-1:0] snext;
    // sequence: first hit wins, scanned from the back so the lowest stays
    sf    = 1'b0;
    sslot = '0;
    snext = s2_i.start + IdxW'(s2_i.cnt);
    for (int i = Slots - 1; i >= 0; i--) begin
      if (s2_i.seq_hit[i]) begin
        sf    = 1'b1;
        sslot = s2_i.seq_slot[i];
        snext = s2_i.start + IdxW'(i);
      end
    end
    // prefer rack: earliest rack, then earliest position
    rf    = 1'b0;
    rslot = '0;
    f1    = 1'b0;
    slot1 = '0;
    for (int r = MaxRacks - 1; r >= 0; r--) begin
      for (int j = Slots - 1; j >= 0; j--) begin
        if (s2_i.hit[r][j]) begin
          rf    = 1'b1;
          rslot = s2_i.rack_slot[j];
        end
        if (s2_i.fb1[r][j]) begin
          f1    = 1'b1;
          slot1 = s2_i.rack_slot[j];
        end
      end
    end
    f2    = 1'b0;
    slot2 = '0;
    for (int j = Slots - 1; j >= 0; j--) begin
      if (s2_i.fb2[j]) begin
        f2    = 1'b1;
        slot2 = s2_i.rack_slot[j];
      end
    end
    // mode select
    unique case (s2_i.kind)
      KIND_MASTER: begin
        res_d.found = s2_i.use0;
        res_d.slot  = '0;
        res_d.next  = s2_i.start;
      end
      KIND_RACK: begin
        priority if (rf) begin
          res_d.found = 1'b1;
          res_d.slot  = rslot;
        end else if (f1) begin
          res_d.found = 1'b1;
          res_d.slot  = slot1;
        end else if (f2) begin
          res_d.found = 1'b1;
          res_d.slot  = slot2;
        end else begin
          res_d.found = 1'b0;
          res_d.slot  = '0;
        end
        res_d.next = res_d.found ? IdxW'(res_d.slot) : s2_i.start;
      end
      KIND_SEQ, KIND_SEQ_ALT: begin
        res_d.found = sf;
        res_d.slot  = sslot;
        res_d.next  = snext;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

// ===== rtl/replica_slot_selector_top.sv =====
// a request passes through three register stages (order, match, pick) to the result
// throughput: one request per cycle; a stall holds the full stages and bubbles close up
// the ready path is a combinational chain from out_ready_i through the three stage enables
// reset: asynchronous active low; clears stage valid bits and sets rack_count to 0
// no clearing pass, the block accepts requests in the first cycle after reset
// ----------------------------------------------------------------------------
// replica_slot_selector_top
// picks the replica slot that serves a request: master, rotating sequence or
// preferred rack with off-rack and previous-slot fallbacks
// ----------------------------------------------------------------------------
`include "replica_slot_selector_top_macros.svh"

module replica_slot_selector_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration
  input  logic                       cfg_we_i,
  input  logic [rss_pkg::CntW-1:0]   cfg_wdata_i,
  // request channel
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 kind_i,
  input  logic [rss_pkg::CntW-1:0]   replica_count_i,
  input  logic [rss_pkg::IdxW-1:0]   start_index_i,
  input  logic [rss_pkg::Slots-1:0]  slot_present_i,
  input  logic [rss_pkg::Slots-1:0]  slot_active_i,
  input  logic [rss_pkg::Slots-1:0]  slot_is_previous_i,
  input  logic [15:0]                rack_match_i,
  // result channel
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       found_o,
  output logic [rss_pkg::SlotW-1:0]  chosen_slot_o,
  output logic [rss_pkg::IdxW-1:0]   next_index_o
);
  import rss_pkg::*;

  logic [CntW-1:0] rack_count_q;
  logic            v1_q, v2_q, v3_q;
  logic            en1, en2, en3;
  s1_t             s1;
  s2_t             s2;
  res_t            res;

  // rack count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rack_count_q <= '0;
    end else if (cfg_we_i) begin
      rack_count_q <= cfg_wdata_i;
    end
  end

  // stage enables, a stage loads when empty or when its content moves on
  assign en3 = !v3_q || out_ready_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign in_ready_o  = en1;
  assign out_valid_o = v3_q;

  // valid bits follow the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  rss_order u_order (
    .clk_i              (clk_i),
    .en_i               (en1),
    .kind_i             (kind_i),
    .replica_count_i    (replica_count_i),
    .start_index_i      (start_index_i),
    .slot_present_i     (slot_present_i),
    .slot_active_i      (slot_active_i),
    .slot_is_previous_i (slot_is_previous_i),
    .rack_match_i       (rack_match_i),
    .rack_count_i       (rack_count_q),
    .s1_o               (s1)
  );

  rss_match u_match (
    .clk_i (clk_i),
    .en_i  (en2),
    .s1_i  (s1),
    .s2_o  (s2)
  );

  rss_pick u_pick (
    .clk_i (clk_i),
    .en_i  (en3),
    .s2_i  (s2),
    .res_o (res)
  );

  assign found_o       = res.found;
  assign chosen_slot_o = res.slot;
  assign next_index_o  = res.next;

  // checks
  `RSS_ASSERT_IMPL(a_slot_zero_on_miss, clk_i, rst_ni, out_valid_o && !found_o, chosen_slot_o == '0)
  `RSS_ASSERT_IMPL(a_stall_only_when_full, clk_i, rst_ni, !in_ready_o, v1_q && v2_q && v3_q && !out_ready_i)
  `RSS_ASSERT_IMPL(a_out_from_stage2, clk_i, rst_ni, $rose(out_valid_o), $past(v2_q))

endmodule
